@@ hdl/glp_pkg.sv @@
// ----------------------------------------------------------------------------
// glp_pkg: shared types for the gcd and lcm pair block
// Sequencer state codes.
// ----------------------------------------------------------------------------
package glp_pkg;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_GCD  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_MUL  = 4'b1000
   } glp_state_type;

endpackage

@@ hdl/gcd_and_lcm_pair.sv @@
// ----------------------------------------------------------------------------
// gcd_and_lcm_pair: greatest common divisor and least common multiple
// Sequence: when either operand is zero the result comes straight from idle;
//   otherwise the binary gcd loop, restoring division of a by the gcd and a
//   shift-add multiply of the quotient by b, then the result strobe.
// Throughput: one word at a time; busy stays high until the result strobe.
// The rate is set by the single shared subtract/compare unit and the adder.
// Reset: synchronous, returns the sequencer to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module gcd_and_lcm_pair
   import glp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [OPERAND_WIDTH-1:0]     req_operand_a,
   input  logic [OPERAND_WIDTH-1:0]     req_operand_b,
   output logic                         rsp_valid,
   output logic [OPERAND_WIDTH-1:0]     rsp_gcd_value,
   output logic [2*OPERAND_WIDTH-1:0]   rsp_lcm_value
);

   localparam int W  = OPERAND_WIDTH;
   localparam int CW = $clog2(W);
   localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

   glp_state_type   state_ff, state_in;
   logic [W-1:0]    x_ff, x_in;
   logic [W-1:0]    y_ff, y_in;
   logic [W-1:0]    b_ff, b_in;
   logic [W-1:0]    gcd_ff, gcd_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [2*W-1:0]  acc_ff, acc_in;
   logic [CW-1:0]   k_ff, k_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            valid_ff, valid_in;
   logic [W-1:0]    a_keep_ff, a_keep_in;

   // shared subtract/compare unit
   logic [W:0]      sub_lhs, sub_rhs;
   logic [W+1:0]    sub_res;
   logic            sub_borrow;
   logic [W:0]      div_shift;

   assign div_shift = {rem_ff, x_ff[W-1]};

   always_comb begin
      case (state_ff)
         ST_DIV: begin
            sub_lhs = div_shift;
            sub_rhs = {1'b0, gcd_ff};
         end
         default: begin
            sub_lhs = {1'b0, x_ff};
            sub_rhs = {1'b0, y_ff};
         end
      endcase
      sub_res    = {1'b0, sub_lhs} - {1'b0, sub_rhs};
      sub_borrow = sub_res[W+1];
   end

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      b_in      = b_ff;
      gcd_in    = gcd_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      a_keep_in = a_keep_ff;
      valid_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operand_a == '0 || req_operand_b == '0) begin
                  gcd_in   = req_operand_a | req_operand_b;
                  acc_in   = '0;
                  valid_in = 1'b1;
               end else begin
                  x_in      = req_operand_a;
                  y_in      = req_operand_b;
                  a_keep_in = req_operand_a;
                  b_in      = req_operand_b;
                  k_in      = '0;
                  state_in  = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (x_ff == '0) begin
               // restore common powers of two, then divide a by the gcd
               gcd_in   = y_ff << k_ff;
               x_in     = a_keep_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!sub_borrow) begin
               x_in = sub_res[W-1:0];
            end else begin
               y_in = W'(~sub_res[W-1:0] + 1'b1);
            end
         end
         ST_DIV: begin
            rem_in = sub_borrow ? div_shift[W-1:0] : sub_res[W-1:0];
            x_in   = {x_ff[W-2:0], ~sub_borrow};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // quotient msb first: shift and add the second operand
            acc_in = {acc_ff[2*W-2:0], 1'b0} + (x_ff[W-1] ? {{W{1'b0}}, b_ff} : '0);
            x_in   = {x_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      b_ff      <= b_in;
      gcd_ff    <= gcd_in;
      rem_ff    <= rem_in;
      acc_ff    <= acc_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      a_keep_ff <= a_keep_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_gcd_value = gcd_ff;
   assign rsp_lcm_value = acc_ff;

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> $past(state_ff == ST_MUL || (state_ff == ST_IDLE && start)))
      else $error("result strobe without a finishing step");

   a_gcd_loop_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> (y_ff != '0))
      else $error("gcd loop lost its nonzero operand");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (gcd_ff != '0 && rem_ff < gcd_ff))
      else $error("division remainder out of range");

   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a start word");

endmodule

@@ bench/gcd_and_lcm_pair_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcd_and_lcm_pair_checker: result checker for the gcd and lcm pair block
// Watches the command and result ports, predicts the gcd and the double
// width lcm of every accepted operand word and compares each result strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module gcd_and_lcm_pair_checker #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [OPERAND_WIDTH-1:0]     req_operand_a,
   input  logic [OPERAND_WIDTH-1:0]     req_operand_b,
   input  logic                         rsp_valid,
   input  logic [OPERAND_WIDTH-1:0]     rsp_gcd_value,
   input  logic [2*OPERAND_WIDTH-1:0]   rsp_lcm_value,
   output int                           mismatch_count,
   output int                           words_pending
);

   typedef struct {
      logic [OPERAND_WIDTH-1:0]   gcd_value;
      logic [2*OPERAND_WIDTH-1:0] lcm_value;
   } gcd_lcm_pair_type;

   gcd_lcm_pair_type pending_pairs[$];

   // Euclid by remainders; lcm is (a / gcd) * b, zero when either operand is zero
   function automatic gcd_lcm_pair_type predict_gcd_lcm(input logic [OPERAND_WIDTH-1:0] a,
                                                        input logic [OPERAND_WIDTH-1:0] b);
      logic [OPERAND_WIDTH-1:0]   x;
      logic [OPERAND_WIDTH-1:0]   y;
      logic [OPERAND_WIDTH-1:0]   r;
      logic [2*OPERAND_WIDTH-1:0] quot;
      gcd_lcm_pair_type           pair;
      x = a;
      y = b;
      while (y != '0) begin
         r = x % y;
         x = y;
         y = r;
      end
      pair.gcd_value = x;
      pair.lcm_value = '0;
      if (a != '0 && b != '0) begin
         quot = {{OPERAND_WIDTH{1'b0}}, a / x};
         pair.lcm_value = quot * {{OPERAND_WIDTH{1'b0}}, b};
      end
      return pair;
   endfunction

   always @(posedge clock) begin
      gcd_lcm_pair_type want;
      if (reset) begin
         mismatch_count <= 0;
         words_pending  <= 0;
      end else begin
         // retire the result before taking a new word in the same cycle
         if (rsp_valid) begin
            if (pending_pairs.size() == 0) begin
               $error("result with no word outstanding: gcd_value %0d, lcm_value %0d",
                      rsp_gcd_value, rsp_lcm_value);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_pairs.pop_front();
               if (rsp_gcd_value !== want.gcd_value || rsp_lcm_value !== want.lcm_value)
                  mismatch_count <= mismatch_count + 1;
               if (rsp_gcd_value !== want.gcd_value)
                  $error("gcd_value mismatch: expected %0d, actual %0d",
                         want.gcd_value, rsp_gcd_value);
               if (rsp_lcm_value !== want.lcm_value)
                  $error("lcm_value mismatch: expected %0d, actual %0d",
                         want.lcm_value, rsp_lcm_value);
            end
         end
         if (start && !busy)
            pending_pairs.push_back(predict_gcd_lcm(req_operand_a, req_operand_b));
         words_pending <= pending_pairs.size();
      end
   end

endmodule

@@ bench/gcd_and_lcm_pair_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcd_and_lcm_pair_tb: testbench top for the gcd and lcm pair block
// Drives directed corner operands and then random operand words in three
// phases of sender idling; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module gcd_and_lcm_pair_tb;

   localparam int OPERAND_WIDTH = 32;
   localparam int PHASE_WORDS   = 230;
   localparam int DRAIN_CYCLES  = 250;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [OPERAND_WIDTH-1:0]     req_operand_a = '0;
   logic [OPERAND_WIDTH-1:0]     req_operand_b = '0;
   logic                         rsp_valid;
   logic [OPERAND_WIDTH-1:0]     rsp_gcd_value;
   logic [2*OPERAND_WIDTH-1:0]   rsp_lcm_value;
   int                           mismatch_count;
   int                           words_pending;
   int                           sender_idle_pct = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   gcd_and_lcm_pair #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_gcd_value (rsp_gcd_value),
      .rsp_lcm_value (rsp_lcm_value)
   );

   gcd_and_lcm_pair_checker #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) CHECK (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_valid      (rsp_valid),
      .rsp_gcd_value  (rsp_gcd_value),
      .rsp_lcm_value  (rsp_lcm_value),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // present one word, idling in random cycles, and hold it until accepted
   task automatic send_operands(input logic [31:0] a, input logic [31:0] b);
      logic offer;
      logic taken;
      req_operand_a <= a;
      req_operand_b <= b;
      taken = 1'b0;
      while (!taken) begin
         offer = ($urandom_range(99) >= sender_idle_pct);
         start <= offer;
         @(posedge clock);
         taken = offer && !busy;
      end
   endtask

   task automatic send_random_operands();
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] factor;
      a = $urandom;
      b = $urandom;
      case ($urandom_range(9))
         1, 2: begin
            // shared factor so the gcd is at least the factor
            factor = ($urandom_range(3) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                              : $urandom_range(1, 65535);
            a = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
            b = factor * $urandom_range(1, 32'hFFFF_FFFF / factor);
         end
         3: begin
            a = $urandom_range(255);
            b = $urandom_range(255);
         end
         4: begin
            case ($urandom_range(4))
               0:       a = '0;
               1:       b = '0;
               2: begin a = '0; b = '0; end
               default: a = '0;
            endcase
         end
         5: b = a;
         6: begin
            a = $urandom_range(1, 65535);
            b = a * $urandom_range(1, 32'hFFFF_FFFF / a);
            if ($urandom_range(1)) begin
               factor = a;
               a = b;
               b = factor;
            end
         end
         7: begin
            a = $urandom << $urandom_range(31);
            b = $urandom << $urandom_range(31);
         end
         8: begin
            a = a | 32'h8000_0000;
            b = b | 32'h8000_0000;
         end
         default: ;
      endcase
      send_operands(a, b);
   endtask

   initial begin
      int idle_plan[3];
      idle_plan = '{21, 78, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_operands(32'd0, 32'd0);
      send_operands(32'd0, 32'd5);
      send_operands(32'd7, 32'd0);
      send_operands(32'd0, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'd0);
      send_operands(32'd1, 32'd1);
      send_operands(32'd1, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_operands(32'hFFFF_FFFF, 32'h0000_FFFF);
      send_operands(32'h8000_0000, 32'h8000_0000);
      send_operands(32'h8000_0000, 32'd1);
      send_operands(32'hC000_0000, 32'h3000_0000);
      send_operands(32'd12, 32'd18);
      send_operands(32'd1071, 32'd462);
      // consecutive Fibonacci numbers: longest remainder chain
      send_operands(32'd2971215073, 32'd1836311903);
      send_operands(32'hAAAA_AAAA, 32'h5555_5555);
      send_operands(32'hFFFF_FFFB, 32'hFFFF_FFF1);

      foreach (idle_plan[p]) begin
         sender_idle_pct = idle_plan[p];
         repeat (PHASE_WORDS) send_random_operands();
      end
      start <= 1'b0;

      while (words_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && words_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/glp_pkg.sv
hdl/gcd_and_lcm_pair.sv
bench/gcd_and_lcm_pair_checker.sv
bench/gcd_and_lcm_pair_tb.sv
